/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/nfas_pkg.sv */
package nfas_pkg;

    // field widths
    localparam int EXP_W    = 32;
    localparam int MANT_W   = 64;
    // exponent with headroom for the +2 / -62 excursions
    localparam int XEXP_W   = EXP_W + 2;
    localparam int SH_W     = 6;

    // normalisation target and shift clamp
    localparam int NORM_TOP  = 62;
    localparam int SHIFT_MAX = 63;

    localparam logic [MANT_W-1:0] MANT_MIN  = {1'b1, {(MANT_W-1){1'b0}}};
    localparam logic [MANT_W-1:0] MANT_MAX  = {1'b0, {(MANT_W-1){1'b1}}};
    localparam logic [MANT_W-1:0] MANT_HALF_NEG = {2'b11, {(MANT_W-2){1'b0}}};

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // input beat
    typedef struct packed {
        logic                     cmd;
        logic signed [EXP_W-1:0]  a_exponent;
        logic signed [MANT_W-1:0] a_mantissa;
        logic signed [EXP_W-1:0]  b_exponent;
        logic signed [MANT_W-1:0] b_mantissa;
    } op_t;

    // after operand alignment set-up
    typedef struct packed {
        logic signed [XEXP_W-1:0] exp;
        logic signed [MANT_W-1:0] m_big;
        logic signed [MANT_W-1:0] m_small;
        logic [SH_W-1:0]          sh;
    } algn_t;

    // after the add
    typedef struct packed {
        logic signed [XEXP_W-1:0] exp;
        logic signed [MANT_W-1:0] sum;
    } sum_t;

    // after leading-one detection
    typedef struct packed {
        logic signed [XEXP_W-1:0] exp;
        logic signed [MANT_W-1:0] sum;
        logic [SH_W-1:0]          shift;
        logic                     zero;
        logic                     most_neg;
    } lzc_t;

    // result beat
    typedef struct packed {
        logic signed [EXP_W-1:0]  sum_exponent;
        logic signed [MANT_W-1:0] sum_mantissa;
        logic                     exponent_overflow;
    } res_t;

endpackage

/* rtl/core/nfas_op_if.sv */
interface nfas_op_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      cmd;
    logic signed [nfas_pkg::EXP_W-1:0]         a_exponent;
    logic signed [nfas_pkg::MANT_W-1:0]        a_mantissa;
    logic signed [nfas_pkg::EXP_W-1:0]         b_exponent;
    logic signed [nfas_pkg::MANT_W-1:0]        b_mantissa;

    modport source (
        output valid, cmd, a_exponent, a_mantissa, b_exponent, b_mantissa,
        input  ready
    );
    modport sink (
        input  valid, cmd, a_exponent, a_mantissa, b_exponent, b_mantissa,
        output ready
    );
endinterface

/* rtl/core/nfas_res_if.sv */
interface nfas_res_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [nfas_pkg::EXP_W-1:0]         sum_exponent;
    logic signed [nfas_pkg::MANT_W-1:0]        sum_mantissa;
    logic                                      exponent_overflow;

    modport source (
        output valid, sum_exponent, sum_mantissa, exponent_overflow,
        input  ready
    );
    modport sink (
        input  valid, sum_exponent, sum_mantissa, exponent_overflow,
        output ready
    );
endinterface

/* rtl/core/normalized_float_add_sub.sv */
// normalised add / subtract of two mantissa-exponent numbers
//
// operand channel: one beat holds cmd (add or subtract b from a), the two
// signed 32-bit exponents and the two signed 64-bit mantissas
// result channel: one beat per operand beat, in order, holding the
// exponent, the mantissa with its magnitude's top bit at bit 62, and a
// flag that the exponent left the 32-bit signed range (it then wraps)
//
// the stages, each ending in a register, are operand set-up, align and add,
// leading-one detection and normalising shift; one beat is taken every
// cycle unless the pipeline is full and the result is stalled
// reset clears the stage valid bits only, so the pipeline comes up empty
// and ready; a stalled result holds in the output register while upstream
// stages keep filling until every stage holds a beat, then operand ready
// drops; nothing is lost or repeated
module normalized_float_add_sub (
    input  logic       clk,
    input  logic       rst_n,
    nfas_op_if.sink    operand,
    nfas_res_if.source result
);

    nfas_pkg::op_t     op_data;
    logic              sum_valid;
    logic              sum_ready;
    nfas_pkg::sum_t    sum_data;
    logic              lzc_valid;
    logic              lzc_ready;
    nfas_pkg::lzc_t    lzc_data;
    nfas_pkg::res_t    res_data;

    // gather the operand beat
    always_comb
    begin
        op_data.cmd        = operand.cmd;
        op_data.a_exponent = operand.a_exponent;
        op_data.a_mantissa = operand.a_mantissa;
        op_data.b_exponent = operand.b_exponent;
        op_data.b_mantissa = operand.b_mantissa;
    end

    nfas_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .in_data   (op_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    nfas_lzc u_lzc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (lzc_valid),
        .out_ready (lzc_ready),
        .out_data  (lzc_data)
    );

    nfas_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lzc_valid),
        .in_ready  (lzc_ready),
        .in_data   (lzc_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_data)
    );

    // result beat
    assign result.sum_exponent      = res_data.sum_exponent;
    assign result.sum_mantissa      = res_data.sum_mantissa;
    assign result.exponent_overflow = res_data.exponent_overflow;

endmodule

/* rtl/core/nfas_align.sv */
module nfas_align (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nfas_pkg::op_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nfas_pkg::sum_t    out_data
);

    logic                                  s1_valid_reg;
    nfas_pkg::algn_t                       s1_data_reg;
    nfas_pkg::algn_t                       s1_data_next;
    logic                                  s1_ready;

    logic                                  s2_valid_reg;
    nfas_pkg::sum_t                        s2_data_reg;
    nfas_pkg::sum_t                        s2_data_next;
    logic                                  s2_ready;

    logic signed [nfas_pkg::MANT_W-1:0]    mb_eff;
    logic signed [nfas_pkg::XEXP_W-1:0]    ea_x;
    logic signed [nfas_pkg::XEXP_W-1:0]    eb_x;
    logic signed [nfas_pkg::XEXP_W-1:0]    diff_ab;
    logic [nfas_pkg::XEXP_W-1:0]           exp_gap;
    logic                                  a_bigger;

    // stage handshake: a stage takes a beat when empty or draining
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // subtract negates b, saturating the most negative value
    always_comb
    begin
        if (in_data.cmd == nfas_pkg::CMD_SUB)
        begin
            if (in_data.b_mantissa == nfas_pkg::MANT_MIN)
                mb_eff = nfas_pkg::MANT_MAX;
            else
                mb_eff = ~in_data.b_mantissa + nfas_pkg::MANT_W'(1);
        end
        else
        begin
            mb_eff = in_data.b_mantissa;
        end
    end

    // exponent compare and clamped shift for the smaller operand
    always_comb
    begin
        ea_x     = nfas_pkg::XEXP_W'(in_data.a_exponent);
        eb_x     = nfas_pkg::XEXP_W'(in_data.b_exponent);
        diff_ab  = ea_x - eb_x;
        a_bigger = !diff_ab[nfas_pkg::XEXP_W-1] && (diff_ab != '0);
        exp_gap  = a_bigger ? diff_ab : -diff_ab;

        if (exp_gap >= nfas_pkg::XEXP_W'(nfas_pkg::SHIFT_MAX))
            s1_data_next.sh = nfas_pkg::SH_W'(nfas_pkg::SHIFT_MAX);
        else
            s1_data_next.sh = exp_gap[nfas_pkg::SH_W-1:0] + nfas_pkg::SH_W'(1);

        s1_data_next.exp     = (a_bigger ? ea_x : eb_x) + nfas_pkg::XEXP_W'(1);
        s1_data_next.m_big   = a_bigger ? in_data.a_mantissa : mb_eff;
        s1_data_next.m_small = a_bigger ? mb_eff : in_data.a_mantissa;
    end

    // halve and align, then add; halving keeps the sum inside 64 bits
    always_comb
    begin
        s2_data_next.exp = s1_data_reg.exp;
        s2_data_next.sum = (s1_data_reg.m_big >>> 1) + (s1_data_reg.m_small >>> s1_data_reg.sh);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_data_reg <= s1_data_next;
        if (s2_ready && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

endmodule

/* rtl/core/nfas_lzc.sv */
module nfas_lzc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nfas_pkg::sum_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nfas_pkg::lzc_t    out_data
);

    logic                                  valid_reg;
    nfas_pkg::lzc_t                        data_reg;
    nfas_pkg::lzc_t                        data_next;
    logic [nfas_pkg::MANT_W-1:0]           mag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // magnitude and position of its top set bit
    always_comb
    begin
        mag = in_data.sum[nfas_pkg::MANT_W-1] ? (~in_data.sum + nfas_pkg::MANT_W'(1))
                                               : in_data.sum;
        data_next.exp      = in_data.exp;
        data_next.sum      = in_data.sum;
        data_next.zero     = (in_data.sum == '0);
        data_next.most_neg = (in_data.sum == nfas_pkg::MANT_MIN);
        data_next.shift    = '0;
        // highest set bit wins
        for (int i = 0; i <= nfas_pkg::NORM_TOP; i++)
        begin
            if (mag[i])
                data_next.shift = nfas_pkg::SH_W'(nfas_pkg::NORM_TOP - i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/nfas_norm.sv */
module nfas_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nfas_pkg::lzc_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nfas_pkg::res_t    out_data
);

    logic                                  valid_reg;
    nfas_pkg::res_t                        data_reg;
    nfas_pkg::res_t                        data_next;
    logic signed [nfas_pkg::XEXP_W-1:0]    exp_adj;
    logic [nfas_pkg::XEXP_W-nfas_pkg::EXP_W:0] exp_top;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // left shift to bit 62 and exponent correction
    always_comb
    begin
        if (in_data.most_neg)
        begin
            exp_adj                = in_data.exp + nfas_pkg::XEXP_W'(1);
            data_next.sum_mantissa = nfas_pkg::MANT_HALF_NEG;
        end
        else
        begin
            exp_adj                = in_data.exp
                                     - {{(nfas_pkg::XEXP_W-nfas_pkg::SH_W){1'b0}}, in_data.shift};
            data_next.sum_mantissa = in_data.sum <<< in_data.shift;
        end

        // out of range when the bits above the sign do not all match it
        exp_top                     = exp_adj[nfas_pkg::XEXP_W-1:nfas_pkg::EXP_W-1];
        data_next.sum_exponent      = exp_adj[nfas_pkg::EXP_W-1:0];
        data_next.exponent_overflow = !((&exp_top) || !(|exp_top));

        // zero sum gives an all-zero result
        if (in_data.zero)
        begin
            data_next.sum_exponent      = '0;
            data_next.sum_mantissa      = '0;
            data_next.exponent_overflow = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* rtl/core/nfas_checker.sv */
`include "assert_macros.svh"

module nfas_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  logic signed [nfas_pkg::EXP_W-1:0]  res_exponent,
    input  logic signed [nfas_pkg::MANT_W-1:0] res_mantissa,
    input  logic                               res_overflow
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // and keeps its payload
    `ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_exponent) && $stable(res_mantissa) && $stable(res_overflow))

    // a zero mantissa comes with exponent zero and no flag
    `ASSERT_IMPLIES(a_zero_result, clk, rst_n, res_valid && (res_mantissa == '0), (res_exponent == '0) && !res_overflow)

    // a nonzero mantissa has its magnitude's top bit at bit 62
    `ASSERT_IMPLIES(a_normalised, clk, rst_n, res_valid && (res_mantissa != '0), (res_mantissa[nfas_pkg::MANT_W-1] != res_mantissa[nfas_pkg::NORM_TOP]) || (res_mantissa == nfas_pkg::MANT_HALF_NEG))

endmodule

bind normalized_float_add_sub nfas_checker u_nfas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_exponent (result.sum_exponent),
    .res_mantissa (result.sum_mantissa),
    .res_overflow (result.exponent_overflow)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam logic signed [nfas_pkg::EXP_W-1:0] EXP_HI = 32'sh7FFF_FFFF;
    localparam logic signed [nfas_pkg::EXP_W-1:0] EXP_LO = 32'sh8000_0000;
    localparam longint EXP_RANGE_TOP    = 64'sd2147483647;
    localparam longint EXP_RANGE_BOTTOM = -64'sd2147483648;
    localparam int RANDOM_OPS  = 1850;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 8;

    logic clk = 1'b0;
    logic rst_n;

    nfas_op_if  operand_bus ();
    nfas_res_if result_bus ();

    normalized_float_add_sub i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_bus),
        .result  (result_bus)
    );

    // operation beats waiting to go out, and the sums they should produce
    nfas_pkg::op_t    pending_ops[$];
    nfas_pkg::res_t   expected_sums[$];
    int               drain_points[$];
    nfas_pkg::op_t    on_bus;
    int     ops_accepted = 0;
    int     total_ops = 0;
    int     mismatches = 0;
    int     gap_left;
    int     stall_left;
    int     cycle_count = 0;
    int     idle_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // aligned add, most-negative fix-up and normalisation to bit 62
    function automatic nfas_pkg::res_t predict_sum(nfas_pkg::op_t op);
        logic signed [nfas_pkg::MANT_W-1:0] ma;
        logic signed [nfas_pkg::MANT_W-1:0] mb;
        logic signed [nfas_pkg::MANT_W-1:0] big;
        logic signed [nfas_pkg::MANT_W-1:0] other;
        logic signed [nfas_pkg::MANT_W-1:0] total;
        logic [nfas_pkg::MANT_W-1:0]        mag;
        longint ea;
        longint eb;
        longint ex;
        longint diff;
        int     sh;
        int     top;
        nfas_pkg::res_t r;
        ma = op.a_mantissa;
        mb = op.b_mantissa;
        ea = op.a_exponent;
        eb = op.b_exponent;
        r = '0;
        // negating the most negative b saturates
        if (op.cmd == nfas_pkg::CMD_SUB)
        begin
            mb = (mb == nfas_pkg::MANT_MIN) ? nfas_pkg::MANT_MAX : -mb;
        end
        if (ea > eb)
        begin
            ex = ea + 1;
            diff = ea - eb;
            big = ma;
            other = mb;
        end
        else
        begin
            ex = eb + 1;
            diff = eb - ea;
            big = mb;
            other = ma;
        end
        sh = (diff + 1 > nfas_pkg::SHIFT_MAX) ? nfas_pkg::SHIFT_MAX : int'(diff + 1);
        total = (big >>> 1) + (other >>> sh);
        if (total == 0)
        begin
            return r;
        end
        if (total == nfas_pkg::MANT_MIN)
        begin
            total = nfas_pkg::MANT_HALF_NEG;
            ex = ex + 1;
        end
        else
        begin
            mag = total[nfas_pkg::MANT_W-1] ? -total : total;
            top = 0;
            for (int i = 0; i < nfas_pkg::MANT_W; i++)
            begin
                if (mag[i])
                begin
                    top = i;
                end
            end
            total = total <<< (nfas_pkg::NORM_TOP - top);
            ex = ex - (nfas_pkg::NORM_TOP - top);
        end
        r.sum_exponent = ex[nfas_pkg::EXP_W-1:0];
        r.sum_mantissa = total;
        r.exponent_overflow = (ex < EXP_RANGE_BOTTOM) || (ex > EXP_RANGE_TOP);
        return r;
    endfunction

    function automatic logic [nfas_pkg::MANT_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mantissas spread over full range, powers of two and corner values
    function automatic logic signed [nfas_pkg::MANT_W-1:0] rand_mantissa();
        logic signed [nfas_pkg::MANT_W-1:0] m;
        m = rand_word();
        case ($urandom_range(0, 9))
            3, 4: m = m >>> $urandom_range(1, 63);
            5, 6: m[nfas_pkg::MANT_W-1:nfas_pkg::MANT_W-2] = $urandom_range(0, 1) ? 2'b01 : 2'b10;
            7:
            begin
                m = $urandom_range(0, 40);
                if ($urandom_range(0, 1))
                begin
                    m = -m;
                end
            end
            8:
            begin
                case ($urandom_range(0, 7))
                    0: m = '0;
                    1: m = -64'sd1;
                    2: m = 64'sd1;
                    3: m = nfas_pkg::MANT_MIN;
                    4: m = nfas_pkg::MANT_MAX;
                    5: m = nfas_pkg::MANT_MIN + 1;
                    6: m = nfas_pkg::MANT_HALF_NEG;
                    default: m = 64'sh4000_0000_0000_0000;
                endcase
            end
            9:
            begin
                m = 64'sd1 <<< $urandom_range(0, 62);
                if ($urandom_range(0, 1))
                begin
                    m = -m;
                end
            end
            default: ;
        endcase
        return m;
    endfunction

    function automatic logic signed [nfas_pkg::EXP_W-1:0] rand_exponent();
        case ($urandom_range(0, 9))
            6, 7: return $urandom;
            8: return EXP_HI - $urandom_range(0, 70);
            9: return EXP_LO + $urandom_range(0, 70);
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_op(logic cmd, logic signed [nfas_pkg::EXP_W-1:0] ae,
                            logic signed [nfas_pkg::MANT_W-1:0] am,
                            logic signed [nfas_pkg::EXP_W-1:0] be,
                            logic signed [nfas_pkg::MANT_W-1:0] bm);
        nfas_pkg::op_t op;
        op.cmd = cmd;
        op.a_exponent = ae;
        op.a_mantissa = am;
        op.b_exponent = be;
        op.b_mantissa = bm;
        pending_ops.push_back(op);
    endtask

    // random beat: near cancellation, nearby exponents or anything at all
    task automatic queue_random_op();
        logic signed [nfas_pkg::EXP_W-1:0]  ae;
        logic signed [nfas_pkg::EXP_W-1:0]  be;
        logic signed [nfas_pkg::MANT_W-1:0] am;
        logic signed [nfas_pkg::MANT_W-1:0] bm;
        logic                               cmd;
        ae = rand_exponent();
        am = rand_mantissa();
        cmd = $urandom_range(0, 1) ? nfas_pkg::CMD_SUB : nfas_pkg::CMD_ADD;
        if ($urandom_range(0, 99) < 15)
        begin
            be = ae - $urandom_range(0, 1);
            bm = am ^ (rand_word() >> $urandom_range(30, 63));
            if (cmd == nfas_pkg::CMD_ADD)
            begin
                bm = -bm;
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                6, 7: be = ae;
                8, 9: be = rand_exponent();
                default: be = ae + (int'($urandom_range(0, 140)) - 70);
            endcase
            bm = rand_mantissa();
        end
        queue_op(cmd, ae, am, be, bm);
    endtask

    // driver: one beat at a time, random idle gaps between beats outside the calm windows
    always @(posedge clk or negedge rst_n)
    begin : drive_operands
        nfas_pkg::op_t nxt;
        logic driver_calm;
        logic holding;
        if (!rst_n)
        begin
            operand_bus.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (operand_bus.valid && operand_bus.ready)
            begin
                expected_sums.push_back(predict_sum(on_bus));
                ops_accepted++;
            end
            // hold off at a drain point until every sum is back
            holding = 1'b0;
            if (drain_points.size() > 0 && drain_points[0] == ops_accepted)
            begin
                if (expected_sums.size() > 0)
                begin
                    holding = 1'b1;
                end
                else
                begin
                    void'(drain_points.pop_front());
                end
            end
            driver_calm = ((cycle_count / 256) % 5 == 0) || ((cycle_count / 256) % 5 == 3);
            if (!operand_bus.valid || operand_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    operand_bus.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 && !holding)
                begin
                    nxt = pending_ops.pop_front();
                    on_bus <= nxt;
                    operand_bus.cmd <= nxt.cmd;
                    operand_bus.a_exponent <= nxt.a_exponent;
                    operand_bus.a_mantissa <= nxt.a_mantissa;
                    operand_bus.b_exponent <= nxt.b_exponent;
                    operand_bus.b_mantissa <= nxt.b_mantissa;
                    operand_bus.valid <= 1'b1;
                    gap_left <= driver_calm ? 0 : draw_idle();
                end
                else
                begin
                    operand_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest predicted sum
    always @(posedge clk or negedge rst_n)
    begin : check_results
        nfas_pkg::res_t want;
        logic monitor_calm;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result beat: exp %0d mant %h ovf %b",
                                 result_bus.sum_exponent, result_bus.sum_mantissa,
                                 result_bus.exponent_overflow);
                    end
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (result_bus.sum_exponent !== want.sum_exponent
                        || result_bus.sum_mantissa !== want.sum_mantissa
                        || result_bus.exponent_overflow !== want.exponent_overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected exp %0d mant %h ovf %b, got exp %0d mant %h ovf %b",
                                     want.sum_exponent, want.sum_mantissa,
                                     want.exponent_overflow, result_bus.sum_exponent,
                                     result_bus.sum_mantissa, result_bus.exponent_overflow);
                        end
                    end
                end
            end
            // random back-pressure; no new stall starts in the calm windows
            monitor_calm = ((cycle_count / 256) % 5 == 0) || ((cycle_count / 256) % 5 == 1);
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!monitor_calm && $urandom_range(0, 99) < 20)
            begin
                result_bus.ready <= 1'b0;
                stall_left <= draw_idle();
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        cycle_count++;
        if ((operand_bus.valid && operand_bus.ready) || (result_bus.valid && result_bus.ready)
            || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        operand_bus.valid = 1'b0;
        operand_bus.cmd = nfas_pkg::CMD_ADD;
        operand_bus.a_exponent = '0;
        operand_bus.a_mantissa = '0;
        operand_bus.b_exponent = '0;
        operand_bus.b_mantissa = '0;
        result_bus.ready = 1'b0;

        // zero sums, most negative sum and saturating negation
        queue_op(nfas_pkg::CMD_ADD, 0, 0, 0, 0);
        queue_op(nfas_pkg::CMD_SUB, 5, 64'sh1234_5678_9ABC_DEF0, 5, 64'sh1234_5678_9ABC_DEF0);
        queue_op(nfas_pkg::CMD_ADD, 7, nfas_pkg::MANT_MIN, 7, nfas_pkg::MANT_MIN);
        queue_op(nfas_pkg::CMD_SUB, 0, 0, 0, nfas_pkg::MANT_MIN);
        queue_op(nfas_pkg::CMD_SUB, -3, nfas_pkg::MANT_MIN, -3, nfas_pkg::MANT_MIN);
        queue_op(nfas_pkg::CMD_ADD, 1, nfas_pkg::MANT_MAX, 1, nfas_pkg::MANT_MAX);
        queue_op(nfas_pkg::CMD_SUB, 2, nfas_pkg::MANT_MAX, 2, nfas_pkg::MANT_MIN);
        // exponent leaving the range at either end
        queue_op(nfas_pkg::CMD_ADD, EXP_HI, nfas_pkg::MANT_MAX, EXP_HI, nfas_pkg::MANT_MAX);
        queue_op(nfas_pkg::CMD_ADD, EXP_HI, nfas_pkg::MANT_MIN, EXP_HI - 1, nfas_pkg::MANT_MIN);
        queue_op(nfas_pkg::CMD_ADD, EXP_LO, 64'sd1, EXP_LO, 0);
        queue_op(nfas_pkg::CMD_SUB, EXP_LO, -64'sd1, EXP_LO, 0);
        // widest exponent gap and shifts around the clamp
        queue_op(nfas_pkg::CMD_ADD, EXP_HI, nfas_pkg::MANT_MAX, EXP_LO, -64'sd1);
        queue_op(nfas_pkg::CMD_ADD, EXP_LO, nfas_pkg::MANT_MIN, EXP_HI, 64'sd1);
        queue_op(nfas_pkg::CMD_ADD, 62, nfas_pkg::MANT_MAX, 0, nfas_pkg::MANT_MAX);
        queue_op(nfas_pkg::CMD_ADD, 0, nfas_pkg::MANT_MIN, 63, nfas_pkg::MANT_HALF_NEG);
        queue_op(nfas_pkg::CMD_SUB, 64, 64'sh4000_0000_0000_0000, 0, nfas_pkg::MANT_MIN);
        // tie, small values and sign change
        queue_op(nfas_pkg::CMD_ADD, 10, -64'sd1, 10, 0);
        queue_op(nfas_pkg::CMD_ADD, -10, 64'sd1, -10, 64'sd1);
        queue_op(nfas_pkg::CMD_SUB, 0, 64'sd1, 0, 64'sd2);
        queue_op(nfas_pkg::CMD_SUB, 3, -64'sd1, 4, -64'sd1);
        drain_points.push_back(pending_ops.size());

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            queue_random_op();
            if (n == RANDOM_OPS / 2)
            begin
                drain_points.push_back(pending_ops.size());
            end
        end
        total_ops = pending_ops.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!(ops_accepted == total_ops && expected_sums.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && expected_sums.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* normalized_float_add_sub.f */
+incdir+rtl/core
rtl/core/nfas_pkg.sv
rtl/core/nfas_op_if.sv
rtl/core/nfas_res_if.sv
rtl/core/nfas_align.sv
rtl/core/nfas_lzc.sv
rtl/core/nfas_norm.sv
rtl/core/normalized_float_add_sub.sv
rtl/core/nfas_checker.sv
tb/testbench.sv
